>>> hw/rtl/tgef_pkg.sv
// ----------------------------------------------------------------------------
// tgef_pkg: shared definitions for the two-row gradient edge filter
// Field widths, register indexes, word types and the gradient function.
// ----------------------------------------------------------------------------
package tgef_pkg;

	localparam int PIX_W         = 8;
	localparam int IMG_W_BITS    = 11;
	localparam int ROW_BITS      = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_VAL_W     = 16;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MIN_WIDTH     = 2;
	localparam int WIDTH_RESET   = 640;
	localparam int HEIGHT_RESET  = 480;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int GRAD_W  = 12;
	localparam int SAT_MAX = 255;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
	} pixel_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] magnitude;
		logic             row_end;
		logic             run_last;
	} result_word_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_VAL_W-1:0] value;
	} cfg_word_t;

	// One column's neighbourhood: left, centre and right of both rows.
	typedef struct packed {
		logic [PIX_W-1:0] pl;
		logic [PIX_W-1:0] pc;
		logic [PIX_W-1:0] pr;
		logic [PIX_W-1:0] ql;
		logic [PIX_W-1:0] qc;
		logic [PIX_W-1:0] qr;
		logic             last;
	} entry_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              nonempty;
	} queue_status_t;

	function automatic logic [PIX_W-1:0] grad_mag(
		input logic [PIX_W-1:0] pl, input logic [PIX_W-1:0] pc, input logic [PIX_W-1:0] pr,
		input logic [PIX_W-1:0] ql, input logic [PIX_W-1:0] qc, input logic [PIX_W-1:0] qr);
		logic [GRAD_W-1:0] top_s, bot_s, lef_s, rig_s, dx, dy, ax, ay, m;
		top_s = GRAD_W'(pl) + GRAD_W'({pc, 1'b0}) + GRAD_W'(pr);
		bot_s = GRAD_W'(ql) + GRAD_W'({qc, 1'b0}) + GRAD_W'(qr);
		lef_s = GRAD_W'(pl) + GRAD_W'({pc, 1'b0}) + GRAD_W'(ql);
		rig_s = GRAD_W'(pr) + GRAD_W'({qc, 1'b0}) + GRAD_W'(qr);
		dx = top_s - bot_s;
		dy = lef_s - rig_s;
		ax = dx[GRAD_W-1] ? (~dx + GRAD_W'(1)) : dx;
		ay = dy[GRAD_W-1] ? (~dy + GRAD_W'(1)) : dy;
		m  = ax + ay;
		return (m >= GRAD_W'(SAT_MAX)) ? PIX_W'(SAT_MAX) : m[PIX_W-1:0];
	endfunction

endpackage

>>> hw/rtl/tgef_stream_if.sv
// ----------------------------------------------------------------------------
// tgef_stream_if: valid/ready channel
// Carries one word of the given type per handshake.
// ----------------------------------------------------------------------------
interface tgef_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/tgef_ram.sv
// ----------------------------------------------------------------------------
// tgef_ram: generic single-port RAM
// Registered read; a write to the read address returns the old contents.
// ----------------------------------------------------------------------------
module tgef_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			rdata <= mem[addr];
			if (we) begin
				mem[addr] <= wdata;
			end
		end
	end

endmodule

>>> hw/rtl/tgef_front.sv
// ----------------------------------------------------------------------------
// tgef_front: pixel intake and classification
// Holds the configuration, tracks column and row, reads and refreshes the
// line store and queues a neighbourhood word for each pixel but a row's first.
// ----------------------------------------------------------------------------
module tgef_front #(
	parameter int MAX_WIDTH = tgef_pkg::MAX_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	tgef_stream_if.sink             pixels,
	tgef_stream_if.sink             cfg,
	input  tgef_pkg::queue_status_t q_status,
	output logic                    push,
	output tgef_pkg::entry_t        push_entry
);
	import tgef_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int CMPW = ((CW + 1) > IMG_W_BITS) ? (CW + 1) : IMG_W_BITS;

	logic [IMG_W_BITS-1:0] width_q;
	logic [ROW_BITS-1:0]   height_q;
	logic [ROW_BITS-1:0]   row_q;
	logic [CW-1:0]         col_q;
	logic [CMPW-1:0]       width_sat;
	logic                  col_last;
	logic                  accept;
	logic [ROW_BITS-1:0]   height_eff;
	logic [ROW_BITS:0]     row_inc;

	logic                  valid_s1;
	logic                  first_s1;
	logic                  last_s1;
	logic                  usep_s1;
	logic [PIX_W-1:0]      q_s1;
	logic [PIX_W-1:0]      ram_rdata;
	logic [PIX_W-1:0]      p_val;
	logic [PIX_W-1:0]      pw0_q, pw1_q, cw0_q, cw1_q;

	assign cfg.ready    = 1'b1;
	// Room is kept for the word still in flight and for the one accepted now.
	assign pixels.ready = ((QCNT_W + 1)'(q_status.count) + (QCNT_W + 1)'(valid_s1))
		< (QCNT_W + 1)'(QUEUE_DEPTH);
	assign accept       = pixels.valid && pixels.ready;

	always_comb begin
		if (CMPW'(width_q) < CMPW'(MIN_WIDTH)) begin
			width_sat = CMPW'(MIN_WIDTH);
		end else if (CMPW'(width_q) > CMPW'(MAX_WIDTH)) begin
			width_sat = CMPW'(MAX_WIDTH);
		end else begin
			width_sat = CMPW'(width_q);
		end
	end

	assign col_last   = CMPW'(col_q) >= (width_sat - CMPW'(1));
	assign height_eff = (height_q == '0) ? ROW_BITS'(1) : height_q;
	assign row_inc    = {1'b0, row_q} + (ROW_BITS + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMG_W_BITS'(WIDTH_RESET);
			height_q <= ROW_BITS'(HEIGHT_RESET);
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_IMAGE_WIDTH:  width_q  <= cfg.data.value[IMG_W_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg.data.value[ROW_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= (row_inc >= {1'b0, height_eff}) ? '0 : row_inc[ROW_BITS-1:0];
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_s1     <= pixels.data.pixel;
			first_s1 <= (col_q == '0);
			last_s1  <= col_last;
			usep_s1  <= (row_q != '0);
		end
	end

	tgef_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.en    (accept),
		.we    (accept),
		.addr  (col_q),
		.wdata (pixels.data.pixel),
		.rdata (ram_rdata)
	);

	// The first row of a frame sees a blank row above it.
	assign p_val = usep_s1 ? ram_rdata : '0;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pw0_q <= first_s1 ? '0 : pw1_q;
			cw0_q <= first_s1 ? '0 : cw1_q;
			pw1_q <= p_val;
			cw1_q <= q_s1;
		end
	end

	// Column zero only primes the window; its result comes with the next pixel.
	assign push       = valid_s1 && !first_s1;
	assign push_entry = '{pl: pw0_q, pc: pw1_q, pr: p_val,
		ql: cw0_q, qc: cw1_q, qr: q_s1, last: last_s1};

endmodule

>>> hw/rtl/tgef_queue.sv
// ----------------------------------------------------------------------------
// tgef_queue: short word queue between intake and output
// A small circular buffer of neighbourhood words with a fill count.
// ----------------------------------------------------------------------------
module tgef_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  tgef_pkg::entry_t        push_entry,
	input  logic                    pop,
	output tgef_pkg::entry_t        head,
	output tgef_pkg::queue_status_t q_status
);
	import tgef_pkg::*;

	entry_t            slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head              = slots_q[rd_ptr_q];
	assign q_status.count    = count_q;
	assign q_status.nonempty = (count_q != '0);

endmodule

>>> hw/rtl/tgef_back.sv
// ----------------------------------------------------------------------------
// tgef_back: gradient evaluation and result output
// Turns each queued word into its result and, at the end of a row, a second
// result for the last column, held in an output register.
// ----------------------------------------------------------------------------
module tgef_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tgef_pkg::entry_t        head,
	input  tgef_pkg::queue_status_t q_status,
	output logic                    pop,
	tgef_stream_if.source           results
);
	import tgef_pkg::*;

	typedef enum logic [1:0] {
		PH_MAIN = 2'b01,
		PH_TAIL = 2'b10
	} phase_t;

	phase_t           phase_q, phase_next;
	logic             res_valid_q;
	result_word_t     res_data_q;
	logic             slot_free;
	logic             work;
	logic [PIX_W-1:0] a_pl, a_pc, a_pr, a_ql, a_qc, a_qr;
	logic             row_end;
	logic             run_last;

	assign slot_free = !res_valid_q || results.ready;
	assign work      = q_status.nonempty && slot_free;

	always_comb begin
		pop        = 1'b0;
		phase_next = phase_q;
		a_pl       = head.pl;
		a_pc       = head.pc;
		a_pr       = head.pr;
		a_ql       = head.ql;
		a_qc       = head.qc;
		a_qr       = head.qr;
		row_end    = 1'b0;
		run_last   = !head.last;
		unique case (phase_q)
			PH_MAIN: begin
				if (work) begin
					if (head.last) begin
						phase_next = PH_TAIL;
					end else begin
						pop = 1'b1;
					end
				end
			end
			PH_TAIL: begin
				// The last column sees blank padding to its right.
				a_pl     = head.pc;
				a_pc     = head.pr;
				a_pr     = '0;
				a_ql     = head.qc;
				a_qc     = head.qr;
				a_qr     = '0;
				row_end  = 1'b1;
				run_last = 1'b1;
				if (work) begin
					pop        = 1'b1;
					phase_next = PH_MAIN;
				end
			end
			default: phase_next = PH_MAIN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MAIN;
			res_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_next;
			if (work) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (work) begin
			res_data_q <= '{magnitude: grad_mag(a_pl, a_pc, a_pr, a_ql, a_qc, a_qr),
				row_end: row_end, run_last: run_last};
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_data_q;

endmodule

>>> hw/rtl/two_row_gradient_edge_filter.sv
// ----------------------------------------------------------------------------
// two_row_gradient_edge_filter: L1 gradient magnitude over two image rows
// An accepted pixel is registered, then joins the queue in the word of the
// column before it, whose result goes from the queue head into the output
// register; the row-end result follows from the same word. Throughput: one
// pixel per cycle while the queue has room, one result word per cycle through
// the single output register while the receiver is ready; W pixels in a row
// yield W results. Reset restores width 640 and height 480, clears counters
// and leaves the line store as is: each frame's first row reads a blank row.
// ----------------------------------------------------------------------------
module two_row_gradient_edge_filter #(
	parameter int MAX_WIDTH = tgef_pkg::MAX_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tgef_stream_if.sink   pixels,
	tgef_stream_if.source results,
	tgef_stream_if.sink   cfg
);
	import tgef_pkg::*;

	logic          push;
	logic          pop;
	entry_t        push_entry;
	entry_t        head;
	queue_status_t q_status;

	tgef_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixels     (pixels),
		.cfg        (cfg),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	tgef_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_status   (q_status)
	);

	tgef_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.results  (results)
	);

	// The intake must never push into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_status.count < QCNT_W'(QUEUE_DEPTH)))
		else $error("word pushed into a full queue");

	// The output side only takes words that are there.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_status.nonempty)
		else $error("word popped from an empty queue");

	// With the queue empty and nothing popped, accepting a pixel leaves at most two words in it.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && pixels.ready && q_status.count == '0 && !pop) |=>
		(q_status.count <= QCNT_W'(2)))
		else $error("queue fill out of step with accepted pixels");

endmodule

>>> sim/two_row_gradient_edge_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_row_gradient_edge_filter_tb: self-checking bench for the edge filter
// Streams grey pixels through the filter while both sides idle at random.
// Every accepted pixel runs through a behavioural copy of the filter. Each
// result word is checked field by field, in order, against that copy. Width
// and height are rewritten between bursts, mid-row and mid-frame included.
// ----------------------------------------------------------------------------
module two_row_gradient_edge_filter_tb;
	import tgef_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
	localparam int LINE_DEPTH    = MAX_WIDTH_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PIXELS = 300;

	logic clk;
	logic arst_n;

	tgef_stream_if #(.T(pixel_word_t))  pix_if ();
	tgef_stream_if #(.T(result_word_t)) res_if ();
	tgef_stream_if #(.T(cfg_word_t))    cfg_if ();

	two_row_gradient_edge_filter DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_if),
		.results (res_if),
		.cfg     (cfg_if)
	);

	// Behavioural copy of the filter state.
	logic [PIX_W-1:0]      line_store [LINE_DEPTH];
	int                    line_fill;
	int                    col_count;
	int                    row_count;
	logic [PIX_W-1:0]      win_p [2];
	logic [PIX_W-1:0]      win_q [2];
	logic [IMG_W_BITS-1:0] width_reg;
	logic [ROW_BITS-1:0]   height_reg;

	result_word_t expected_results [$];
	pixel_word_t  pixel_queue [$];
	logic [PIX_W-1:0] recent_pixel;
	logic pix_taken;
	int   cycle_count;
	int   failures;
	logic stall_free;

	assign stall_free = (cycle_count % 2500) < 600;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int active_width(input logic [IMG_W_BITS-1:0] raw);
		if (raw < MIN_WIDTH)
			return MIN_WIDTH;
		if (raw > LINE_DEPTH)
			return LINE_DEPTH;
		return int'(raw);
	endfunction

	function automatic logic [PIX_W-1:0] l1_gradient(input int pl, input int pc, input int pr,
		input int ql, input int qc, input int qr);
		int gx, gy, m;
		gx = (pl + 2 * pc + pr) - (ql + 2 * qc + qr);
		gy = (pl + 2 * pc + ql) - (pr + 2 * qc + qr);
		m  = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
		return (m >= SAT_MAX) ? PIX_W'(SAT_MAX) : PIX_W'(m);
	endfunction

	task automatic expect_word(input logic [PIX_W-1:0] mag, input logic row_end,
		input logic run_last);
		result_word_t w;
		w.magnitude = mag;
		w.row_end   = row_end;
		w.run_last  = run_last;
		expected_results.push_back(w);
	endtask

	// Advances the filter copy by one pixel and queues the words it causes.
	task automatic filter_pixel(input logic [PIX_W-1:0] px);
		int w, h, c, above;
		bit row_last;
		w = active_width(width_reg);
		h = (height_reg == 0) ? 1 : int'(height_reg);
		c = (col_count >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_count;
		row_last = c >= w - 1;
		above = (row_count != 0) ? int'(line_store[c]) : 0;
		line_store[c] = px;
		if (c + 1 > line_fill)
			line_fill = c + 1;
		if (c == 0) begin
			win_p[0] = '0;
			win_q[0] = '0;
		end else begin
			expect_word(l1_gradient(win_p[0], win_p[1], above, win_q[0], win_q[1], px),
				1'b0, !row_last);
			win_p[0] = win_p[1];
			win_q[0] = win_q[1];
		end
		win_p[1] = PIX_W'(above);
		win_q[1] = px;
		if (row_last) begin
			// The last column sees zero padding on its right.
			expect_word(l1_gradient(win_p[0], win_p[1], 0, win_q[0], win_q[1], 0), 1'b1, 1'b1);
			col_count = 0;
			row_count = (row_count + 1 >= h) ? 0 : row_count + 1;
			win_p[0] = '0;
			win_p[1] = '0;
			win_q[0] = '0;
			win_q[1] = '0;
		end else begin
			col_count = c + 1;
		end
	endtask

	// Pixel driver: a word stays on the bus until it has been taken.
	always @(posedge clk) begin
		pix_taken <= pix_if.valid && pix_if.ready;
		if (pix_if.valid && pix_if.ready)
			filter_pixel(pix_if.data.pixel);
	end

	always @(negedge clk) begin
		if (arst_n && (!pix_if.valid || pix_taken)) begin
			if (pixel_queue.size() != 0 && (stall_free || $urandom_range(0, 99) >= 9)) begin
				pix_if.valid <= 1'b1;
				pix_if.data  <= pixel_queue.pop_front();
			end else begin
				pix_if.valid <= 1'b0;
			end
		end
	end

	// Result monitor.
	always @(negedge clk) begin
		if (arst_n)
			res_if.ready <= stall_free || $urandom_range(0, 99) >= 9;
	end

	always @(posedge clk) begin : result_check
		result_word_t want;
		cycle_count <= cycle_count + 1;
		if (res_if.valid && res_if.ready) begin
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected: magnitude %0d, row_end %0b, run_last %0b",
					res_if.data.magnitude, res_if.data.row_end, res_if.data.run_last);
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (res_if.data.magnitude !== want.magnitude) begin
					$error("magnitude: expected %0d, got %0d", want.magnitude,
						res_if.data.magnitude);
					failures++;
				end
				if (res_if.data.row_end !== want.row_end) begin
					$error("row_end: expected %0b, got %0b", want.row_end, res_if.data.row_end);
					failures++;
				end
				if (res_if.data.run_last !== want.run_last) begin
					$error("run_last: expected %0b, got %0b", want.run_last,
						res_if.data.run_last);
					failures++;
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_VAL_W-1:0] value);
		@(negedge clk);
		cfg_if.valid       <= 1'b1;
		cfg_if.data.index  <= idx;
		cfg_if.data.value  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_IMAGE_WIDTH:  width_reg = value[IMG_W_BITS-1:0];
			REG_IMAGE_HEIGHT: height_reg = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Mid-frame the width may only grow over line store entries that hold a pixel.
	task automatic set_width(input int requested, input logic [4:0] upper);
		int w;
		w = requested;
		if (row_count != 0 && active_width(IMG_W_BITS'(w)) > line_fill)
			w = line_fill;
		write_reg(REG_IMAGE_WIDTH, {upper, IMG_W_BITS'(w)});
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel(input logic [PIX_W-1:0] prev);
		case ($urandom_range(0, 9))
			0, 1: return '0;
			2, 3: return '1;
			4: return prev + PIX_W'($urandom_range(0, 6)) - PIX_W'(3);
			default: return PIX_W'($urandom);
		endcase
	endfunction

	task automatic push_pixel(input logic [PIX_W-1:0] v);
		pixel_word_t w;
		w.pixel = v;
		pixel_queue.push_back(w);
		recent_pixel = v;
	endtask

	task automatic queue_pixels(input int n);
		repeat (n)
			push_pixel(rand_pixel(recent_pixel));
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pixel_queue.size() != 0 || pix_if.valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Ends the current frame so that the next pixel starts row zero.
	task automatic close_frame();
		int w;
		write_reg(REG_IMAGE_HEIGHT, CFG_VAL_W'(1));
		w = active_width(width_reg);
		queue_pixels((col_count >= w - 1) ? 1 : w - col_count);
		wait_idle();
	endtask

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int random_sent, n, w, h;
		arst_n       = 1'b0;
		pix_if.valid = 1'b0;
		pix_if.data  = '0;
		res_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data  = '0;
		pix_taken    = 1'b0;
		cycle_count  = 0;
		failures     = 0;
		recent_pixel = '0;
		line_fill    = 0;
		col_count    = 0;
		row_count    = 0;
		win_p[0] = '0;
		win_p[1] = '0;
		win_q[0] = '0;
		win_q[1] = '0;
		width_reg  = IMG_W_BITS'(WIDTH_RESET);
		height_reg = ROW_BITS'(HEIGHT_RESET);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset geometry: these four stay inside the first, blank-topped row.
		push_pixel('1);
		push_pixel('0);
		push_pixel('1);
		push_pixel('0);
		wait_idle();
		// Shrinking below the current column closes the row on the next pixel.
		set_width(3, '0);
		push_pixel('1);
		wait_idle();
		write_reg(REG_IMAGE_HEIGHT, CFG_VAL_W'(2));
		push_pixel('0);
		push_pixel('1);
		push_pixel('1);
		wait_idle();
		push_pixel('1);
		push_pixel('1);
		push_pixel('1);
		wait_idle();
		// Width below the minimum and a zero height, with junk above the width field.
		set_width(0, '1);
		write_reg(REG_IMAGE_HEIGHT, '0);
		push_pixel('1);
		push_pixel('0);
		push_pixel('0);
		push_pixel('1);
		wait_idle();
		set_width(1, '0);
		write_reg(REG_IMAGE_HEIGHT, '1);
		push_pixel('0);
		push_pixel('1);
		push_pixel('1);
		push_pixel('0);
		push_pixel(PIX_W'(128));
		push_pixel(PIX_W'(127));
		wait_idle();

		// A full-width row fills the whole line store; the next row reads it back.
		close_frame();
		set_width(2047, '0);
		write_reg(REG_IMAGE_HEIGHT, CFG_VAL_W'(2));
		queue_pixels(LINE_DEPTH);
		wait_idle();

		random_sent = 0;
		while (random_sent < RANDOM_PIXELS) begin
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 19))
					0:       w = $urandom_range(0, 1);
					1:       w = $urandom_range(1024, 2047);
					2, 3, 4: w = $urandom_range(13, 100);
					default: w = $urandom_range(2, 12);
				endcase
				set_width(w, ($urandom_range(0, 7) == 0) ? 5'($urandom) : '0);
			end
			if ($urandom_range(0, 9) < 4) begin
				case ($urandom_range(0, 9))
					0:       h = 0;
					1:       h = 65535;
					2:       h = $urandom_range(0, 65535);
					default: h = $urandom_range(1, 4);
				endcase
				write_reg(REG_IMAGE_HEIGHT, CFG_VAL_W'(h));
			end
			if ($urandom_range(0, 19) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_VAL_W'($urandom));
			n = $urandom_range(1, 40);
			queue_pixels(n);
			random_sent += n;
			wait_idle();
		end

		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/tgef_pkg.sv
hw/rtl/tgef_stream_if.sv
hw/rtl/tgef_ram.sv
hw/rtl/tgef_front.sv
hw/rtl/tgef_queue.sv
hw/rtl/tgef_back.sv
hw/rtl/two_row_gradient_edge_filter.sv
sim/two_row_gradient_edge_filter_tb.sv
